// File: rtl/core/tpbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture pixel blend write: shared definitions
// Field widths, operator and register codes, reset values, the sequencer
// states and the byte blend function used by the read-modify-write path.
// ----------------------------------------------------------------------------
package tpbw_pkg;

  localparam int DEF_MAX_WIDTH    = 64;
  localparam int DEF_MAX_HEIGHT   = 64;
  localparam int DEF_MAX_CHANNELS = 4;

  // Four memory banks picked by the low address bits; consecutive bytes land in distinct banks.
  localparam int NUM_LANES  = 4;
  localparam int LANE_SEL_W = 2;

  localparam int KIND_W      = 3;
  localparam int COORD_W     = 8;
  localparam int PIX_W       = 8;
  localparam int DIM_W       = 7;
  localparam int CH_W        = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [KIND_W-1:0] OP_REPLACE  = 3'd0;
  localparam logic [KIND_W-1:0] OP_ADD      = 3'd1;
  localparam logic [KIND_W-1:0] OP_MULTIPLY = 3'd2;
  localparam logic [KIND_W-1:0] OP_SUBTRACT = 3'd3;
  localparam logic [KIND_W-1:0] OP_DIVIDE   = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 7'd64;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 7'd64;
  localparam logic [CH_W-1:0]  RST_CHANNEL_COUNT = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_BASE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_t;

  // Saturating blend of one byte. For a divide by a nonzero operand the old
  // value is returned as the dividend that the serial divider starts from.
  function automatic logic [PIX_W-1:0] blend_byte(input logic [KIND_W-1:0] op,
                                                  input logic [PIX_W-1:0]  old_v,
                                                  input logic [PIX_W-1:0]  val);
    logic [PIX_W:0]     sum;
    logic [2*PIX_W-1:0] prod;
    logic [PIX_W-1:0]   r;
    sum  = {1'b0, old_v} + {1'b0, val};
    prod = {{PIX_W{1'b0}}, old_v} * {{PIX_W{1'b0}}, val};
    case (op)
      OP_REPLACE:  r = val;
      OP_ADD:      r = sum[PIX_W] ? '1 : sum[PIX_W-1:0];
      OP_MULTIPLY: r = (prod[2*PIX_W-1:PIX_W] != '0) ? '1 : prod[PIX_W-1:0];
      OP_SUBTRACT: r = (old_v >= val) ? old_v - val : '0;
      OP_DIVIDE:   r = (val == '0) ? '1 : old_v;
      default:     r = old_v;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/tpbw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tpbw_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/texture_pixel_blend_write_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture pixel blend write
// A pixel write inside the byte texture reads every configured channel of the
// pixel, blends it with the operand (replace, add, multiply, subtract, divide),
// clamps to 0..255, writes it back and returns the new bytes and an in-bounds flag.
// ----------------------------------------------------------------------------
// After reset the block zeroes the texture in a clearing pass over all
// ceil(MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS/4) bank rows (4096 at the defaults) and
// takes no request meanwhile. The texture sits in four byte-wide banks so that
// all channels of a pixel are read together and written back together.
// A request that falls inside the texture passes through address arithmetic
// (ST_ADDR, ST_BASE), the memory read, the blend and the write-back before the
// next acceptance. A divide by a nonzero operand adds the bit-serial divider
// (ST_DIV). A request outside the texture skips from ST_ADDR to ST_DONE. The
// result sits in an output register, so the next request is taken while a
// result still waits; the write-back stalls only when that register is full.
// Configuration may be written at any time the block holds no request.
// ----------------------------------------------------------------------------
module texture_pixel_blend_write_top #(
  parameter int MAX_WIDTH    = tpbw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = tpbw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = tpbw_pkg::DEF_MAX_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // x_coord[7:0], y_coord[15:8], pixel_value[23:16]
  input  logic [tpbw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // kind[2:0]
  input  logic [tpbw_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // in_bounds[0], new_value_0[8:1], new_value_1[16:9], new_value_2[24:17],
  // new_value_3[32:25], zero[39:33]
  output logic [tpbw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpbw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tpbw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import tpbw_pkg::*;

  localparam int DIM_MAX     = (1 << DIM_W) - 1;
  localparam int W_CAP       = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
  localparam int H_CAP       = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
  localparam int PIXELS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_DEPTH = PIXELS * MAX_CHANNELS;
  localparam int BANK_DEPTH  = (STORE_DEPTH + NUM_LANES - 1) / NUM_LANES;
  localparam int ROW_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int AW          = ROW_W + LANE_SEL_W;
  localparam int PW          = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CNT_W       = $clog2(PIX_W);

  localparam logic [DIM_W-1:0] W_CAP_V    = DIM_W'(W_CAP);
  localparam logic [DIM_W-1:0] H_CAP_V    = DIM_W'(H_CAP);
  localparam logic [CH_W-1:0]  CH_CAP_V   = CH_W'(MAX_CHANNELS);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(BANK_DEPTH - 1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(PIX_W - 1);

  state_t state, state_next;

  // Configuration registers
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [CH_W-1:0]  channel_count;
  logic [DIM_W-1:0] w_sat;
  logic [DIM_W-1:0] h_sat;
  logic [CH_W-1:0]  ch_sat;

  // Request being worked on
  logic [KIND_W-1:0]  item_kind;
  logic [COORD_W-1:0] item_x;
  logic [COORD_W-1:0] item_y;
  logic [PIX_W-1:0]   item_val;

  logic               in_texture;
  logic               inside_calc;
  logic [2*DIM_W:0]   pixel_full;
  logic [PW-1:0]      pixel;
  logic [AW-1:0]      base;
  logic [PIX_W-1:0]   lane_val [NUM_LANES];
  logic [PIX_W-1:0]   div_rem  [NUM_LANES];
  logic [CNT_W-1:0]   div_cnt;
  logic [ROW_W-1:0]   clr_row;

  logic                  lane_en   [NUM_LANES];
  logic [LANE_SEL_W-1:0] lane_bank [NUM_LANES];
  logic [PIX_W-1:0]      lane_old  [NUM_LANES];
  logic [LANE_SEL_W-1:0] bank_lane [NUM_LANES];
  logic [AW-1:0]         bank_addr [NUM_LANES];
  logic                  bank_en   [NUM_LANES];

  logic                  ram_we    [NUM_LANES];
  logic [ROW_W-1:0]      ram_waddr [NUM_LANES];
  logic [PIX_W-1:0]      ram_wdata [NUM_LANES];
  logic                  ram_re    [NUM_LANES];
  logic [ROW_W-1:0]      ram_raddr [NUM_LANES];
  logic [PIX_W-1:0]      ram_rdata [NUM_LANES];

  logic                   done_fire;
  logic [OUT_TDATA_W-1:0] out_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign done_fire     = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  assign w_sat  = (image_width > W_CAP_V) ? W_CAP_V : image_width;
  assign h_sat  = (image_height > H_CAP_V) ? H_CAP_V : image_height;
  assign ch_sat = (channel_count > CH_CAP_V) ? CH_CAP_V : channel_count;

  // Negative coordinates have the sign bit set and fail the compare.
  assign inside_calc = (item_x < {1'b0, w_sat}) && (item_y < {1'b0, h_sat});
  assign pixel_full  = (2*DIM_W+1)'(item_y[DIM_W-1:0] * w_sat)
                       + (2*DIM_W+1)'(item_x[DIM_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      channel_count <= RST_CHANNEL_COUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[DIM_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte lane c of the pixel lives at base + c; its bank is the low address bits.
  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      lane_en[c]   = (CH_W'(c) < ch_sat);
      lane_bank[c] = base[LANE_SEL_W-1:0] + LANE_SEL_W'(c);
      lane_old[c]  = ram_rdata[lane_bank[c]];
    end
    for (int b = 0; b < NUM_LANES; b++) begin
      bank_lane[b] = LANE_SEL_W'(b) - base[LANE_SEL_W-1:0];
      bank_addr[b] = base + AW'(bank_lane[b]);
      bank_en[b]   = lane_en[bank_lane[b]];
    end
  end

  always_comb begin
    for (int b = 0; b < NUM_LANES; b++) begin
      ram_re[b]    = (state == ST_READ) && bank_en[b];
      ram_raddr[b] = bank_addr[b][AW-1:LANE_SEL_W];
      if (state == ST_CLEAR) begin
        ram_we[b]    = 1'b1;
        ram_waddr[b] = clr_row;
        ram_wdata[b] = '0;
      end else begin
        ram_we[b]    = done_fire && in_texture && bank_en[b];
        ram_waddr[b] = bank_addr[b][AW-1:LANE_SEL_W];
        ram_wdata[b] = lane_val[bank_lane[b]];
      end
    end
  end

  for (genvar b = 0; b < NUM_LANES; b++) begin : g_bank
    tpbw_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (ram_we[b]),
      .waddr (ram_waddr[b]),
      .wdata (ram_wdata[b]),
      .re    (ram_re[b]),
      .raddr (ram_raddr[b]),
      .rdata (ram_rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_row == ROW_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_ADDR;
      ST_ADDR:  state_next = inside_calc ? ST_BASE : ST_DONE;
      ST_BASE:  state_next = ST_READ;
      ST_READ:  state_next = ST_CALC;
      ST_CALC: begin
        if (item_kind == OP_DIVIDE && item_val != '0) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV:   if (div_cnt == DIV_LAST) state_next = ST_DONE;
      ST_DONE:  if (done_fire) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        item_x    <= s_axis_tdata[COORD_W-1:0];
        item_y    <= s_axis_tdata[2*COORD_W-1:COORD_W];
        item_val  <= s_axis_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
        item_kind <= s_axis_tuser;
      end
      ST_ADDR: begin
        in_texture <= inside_calc;
        pixel      <= PW'(pixel_full);
      end
      ST_BASE: begin
        base <= AW'(AW'(pixel) * AW'(ch_sat));
      end
      ST_CALC: begin
        div_cnt <= '0;
        for (int c = 0; c < NUM_LANES; c++) begin
          lane_val[c] <= blend_byte(item_kind, lane_old[c], item_val);
          div_rem[c]  <= '0;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle; lane_val shifts the
        // dividend out and the quotient in.
        div_cnt <= div_cnt + 1'b1;
        for (int c = 0; c < NUM_LANES; c++) begin
          if ({div_rem[c], lane_val[c][PIX_W-1]} >= {1'b0, item_val}) begin
            div_rem[c]  <= PIX_W'({div_rem[c], lane_val[c][PIX_W-1]} - {1'b0, item_val});
            lane_val[c] <= {lane_val[c][PIX_W-2:0], 1'b1};
          end else begin
            div_rem[c]  <= {div_rem[c][PIX_W-2:0], lane_val[c][PIX_W-1]};
            lane_val[c] <= {lane_val[c][PIX_W-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_next    = '0;
    out_next[0] = in_texture;
    for (int c = 0; c < NUM_LANES; c++) begin
      if (in_texture && lane_en[c]) begin
        out_next[1 + c*PIX_W +: PIX_W] = lane_val[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      m_axis_tdata <= out_next;
    end
  end

endmodule

// File: tb/sv/texture_pixel_blend_write_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture pixel blend write: self-checking testbench
// Streams pixel write requests into the block under several texture shapes and
// channel counts. A scoreboard keeps its own copy of the texture, predicts the
// in-bounds flag and the new channel bytes of every request, and compares each
// returned result with the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module texture_pixel_blend_write_top_test;
  import tpbw_pkg::*;

  localparam int TEXEL_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * DEF_MAX_CHANNELS;
  localparam int RANDOM_ITEMS = 1200;
  localparam int NUM_SETTINGS = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_IDLE     = 13;

  // The operator field is three bits wide; these codes have no operation.
  localparam logic [KIND_W-1:0] OP_RESERVED_5 = 3'd5;
  localparam logic [KIND_W-1:0] OP_RESERVED_6 = 3'd6;
  localparam logic [KIND_W-1:0] OP_RESERVED_7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [PIX_W-1:0]   pixel_value;
  } pixel_write_t;

  typedef struct packed {
    logic [3:0][PIX_W-1:0] channel_value;
    logic                  in_bounds;
  } pixel_result_t;

  class texel_blend_checker;
    logic [PIX_W-1:0] texels [TEXEL_DEPTH];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [CH_W-1:0]  channels_reg;
    pixel_result_t    expected_results[$];
    int               mismatches;
    int               result_count;

    function new();
      foreach (texels[i]) texels[i] = '0;
      width_reg    = RST_IMAGE_WIDTH;
      height_reg   = RST_IMAGE_HEIGHT;
      channels_reg = RST_CHANNEL_COUNT;
      mismatches   = 0;
      result_count = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_IMAGE_WIDTH:   width_reg = data;
        REG_IMAGE_HEIGHT:  height_reg = data;
        REG_CHANNEL_COUNT: channels_reg = data[CH_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] blended(logic [KIND_W-1:0] op, int unsigned old_v,
                                       int unsigned operand);
      int unsigned r;
      case (op)
        OP_REPLACE:  r = operand;
        OP_ADD:      r = old_v + operand;
        OP_MULTIPLY: r = old_v * operand;
        OP_SUBTRACT: r = (old_v >= operand) ? old_v - operand : 0;
        OP_DIVIDE:   r = (operand == 0) ? 255 : old_v / operand;
        default:     r = old_v;
      endcase
      if (r > 255) r = 255;
      return r[PIX_W-1:0];
    endfunction

    // Applies one accepted request to the texture copy and queues its result.
    function void note_write(pixel_write_t w);
      int unsigned   wd, ht, ch, xu, yu, addr;
      pixel_result_t want;
      wd   = (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
      ht   = (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
      ch   = (channels_reg > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : channels_reg;
      xu   = w.x_coord;
      yu   = w.y_coord;
      want = '0;
      if (!w.x_coord[COORD_W-1] && !w.y_coord[COORD_W-1] && xu < wd && yu < ht) begin
        want.in_bounds = 1'b1;
        for (int c = 0; c < ch; c++) begin
          addr = (yu * wd + xu) * ch + c;
          if (addr < TEXEL_DEPTH) begin
            texels[addr] = blended(w.kind, texels[addr], w.pixel_value);
            want.channel_value[c] = texels[addr];
          end
        end
      end
      expected_results.push_back(want);
    endfunction

    function void report_mismatch(string field, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d, got %0d", result_count, field, want, got);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      pixel_result_t want;
      result_count++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request pending: %h", result_count, data);
        return;
      end
      want = expected_results.pop_front();
      if (data[0] !== want.in_bounds)
        report_mismatch("in_bounds", want.in_bounds, data[0]);
      for (int c = 0; c < 4; c++) begin
        if (data[1 + c*PIX_W +: PIX_W] !== want.channel_value[c])
          report_mismatch($sformatf("new_value_%0d", c), want.channel_value[c],
                          data[1 + c*PIX_W +: PIX_W]);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  texel_blend_checker sb = new();
  int unsigned        cycle_count = 0;
  bit                 src_steady = 1'b0;
  bit                 snk_steady = 1'b0;
  int unsigned        cur_width = RST_IMAGE_WIDTH;
  int unsigned        cur_height = RST_IMAGE_HEIGHT;

  // Width, height and channel count of each phase; zeros and all-ones included.
  int unsigned setting_width    [NUM_SETTINGS] = '{64, 8, 1, 127, 0, 5, 3, 64, 2};
  int unsigned setting_height   [NUM_SETTINGS] = '{64, 4, 1, 127, 5, 0, 3, 64, 64};
  int unsigned setting_channels [NUM_SETTINGS] = '{4, 3, 1, 7, 2, 4, 0, 2, 4};

  texture_pixel_blend_write_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at a falling edge with tvalid low.
  task automatic send_write(input pixel_write_t w);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, MAX_IDLE);
    repeat (gap) @(negedge clk);
    s_axis_tdata  = {w.pixel_value, w.y_coord, w.x_coord};
    s_axis_tuser  = w.kind;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_write(w);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
  endtask

  task automatic send_direct(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] value);
    send_write('{kind: kind, x_coord: x, y_coord: y, pixel_value: value});
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index = index;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_register(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input int unsigned wd, input int unsigned ht, input int unsigned ch);
    wait_drained();
    write_register(REG_IMAGE_WIDTH, wd[CFG_DATA_W-1:0]);
    write_register(REG_IMAGE_HEIGHT, ht[CFG_DATA_W-1:0]);
    write_register(REG_CHANNEL_COUNT, ch[CFG_DATA_W-1:0]);
    cur_width  = wd;
    cur_height = ht;
  endtask

  // Mostly requests inside the texture, many on a few hot pixels so that the
  // read-modify-write path sees back-to-back hits; the rest is random noise.
  function automatic pixel_write_t random_write();
    pixel_write_t w;
    int unsigned  wd, ht, pick;
    wd = (cur_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_width;
    ht = (cur_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cur_height;
    w.kind = ($urandom_range(0, 99) < 85) ? KIND_W'($urandom_range(OP_REPLACE, OP_DIVIDE))
                                           : KIND_W'($urandom_range(OP_RESERVED_5,
                                                                    OP_RESERVED_7));
    pick = $urandom_range(0, 9);
    if (pick == 0)      w.pixel_value = '0;
    else if (pick == 1) w.pixel_value = '1;
    else if (pick == 2) w.pixel_value = PIX_W'($urandom_range(1, 3));
    else                w.pixel_value = PIX_W'($urandom);
    if ($urandom_range(0, 99) < 75 && wd > 0 && ht > 0) begin
      if ($urandom_range(0, 1) == 0) begin
        w.x_coord = COORD_W'($urandom_range(0, (wd < 3 ? wd : 3) - 1));
        w.y_coord = COORD_W'($urandom_range(0, (ht < 3 ? ht : 3) - 1));
      end else begin
        w.x_coord = COORD_W'($urandom_range(0, wd - 1));
        w.y_coord = COORD_W'($urandom_range(0, ht - 1));
      end
    end else begin
      w.x_coord = COORD_W'($urandom);
      w.y_coord = COORD_W'($urandom);
    end
    return w;
  endfunction

  initial begin
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      m_axis_tready = 1'b0;
      repeat (snk_steady ? 0 : $urandom_range(0, MAX_IDLE)) @(negedge clk);
      m_axis_tready = 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      sb.check_result(m_axis_tdata);
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) snk_steady = !snk_steady;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Saturation, exact fits, divide by zero and the unused operator codes.
    send_direct(OP_REPLACE, 0, 0, 200);
    send_direct(OP_ADD, 0, 0, 100);
    send_direct(OP_SUBTRACT, 0, 0, 255);
    send_direct(OP_SUBTRACT, 0, 0, 1);
    send_direct(OP_REPLACE, 0, 0, 17);
    send_direct(OP_MULTIPLY, 0, 0, 16);
    send_direct(OP_REPLACE, 1, 0, 15);
    send_direct(OP_MULTIPLY, 1, 0, 17);
    send_direct(OP_DIVIDE, 1, 0, 0);
    send_direct(OP_DIVIDE, 1, 0, 2);
    send_direct(OP_DIVIDE, 1, 0, 255);
    send_direct(OP_ADD, 63, 63, 255);
    send_direct(OP_MULTIPLY, 63, 63, 0);
    send_direct(OP_RESERVED_5, 0, 0, 99);
    send_direct(OP_RESERVED_6, 1, 0, 0);
    send_direct(OP_RESERVED_7, 63, 63, 255);
    // Negative, past-the-edge and edge coordinates.
    send_direct(OP_REPLACE, -1, 0, 1);
    send_direct(OP_REPLACE, 0, -128, 1);
    send_direct(OP_REPLACE, 64, 0, 1);
    send_direct(OP_REPLACE, 0, 64, 1);
    send_direct(OP_REPLACE, 127, 127, 255);
    send_direct(OP_REPLACE, -128, -1, 0);
    send_direct(OP_REPLACE, 63, 0, 255);
    send_direct(OP_REPLACE, 0, 63, 128);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      configure(setting_width[s], setting_height[s], setting_channels[s]);
      for (int n = 0; n < RANDOM_ITEMS / NUM_SETTINGS; n++) begin
        // Let the pipeline run dry once in the middle of a phase.
        if (s == 1 && n == 60) wait_drained();
        send_write(random_write());
      end
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tpbw_pkg.sv
rtl/core/tpbw_ram.sv
rtl/core/texture_pixel_blend_write_top.sv
tb/sv/texture_pixel_blend_write_top_test.sv
